/* rtl/radial_weighted_field_blur_macros.svh */
// Assertion macros shared by the checker
`ifndef RADIAL_WEIGHTED_FIELD_BLUR_MACROS_SVH
`define RADIAL_WEIGHTED_FIELD_BLUR_MACROS_SVH
// implication checked at every clock edge outside reset
`define RWFB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication checked outside reset
`define RWFB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* rtl/rwfb_pkg.sv */
//------------------------------------------------------------------------------
// rwfb_pkg
// Types and constants for the radial weighted field blur.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package rwfb_pkg;
    localparam int CFG_W = 11;
    localparam logic [1:0] REG_ROWS   = 2'd0;
    localparam logic [1:0] REG_COLS   = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;
    localparam logic [1:0] REG_RSQ    = 2'd3;
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic               op;
        logic [6:0]         row;
        logic [6:0]         col;
        logic signed [15:0] height;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] blurred_height;
        logic               invalid;
    } t_out_word;

    // request to the divider
    typedef struct packed {
        logic               start;
        logic [47:0]        mag;
        logic [23:0]        den;
    } t_div_req;
endpackage

/* rtl/rwfb_div.sv */
//------------------------------------------------------------------------------
// rwfb_div
// Restoring divider, one quotient bit per cycle, rounding half away from zero.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module rwfb_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rwfb_pkg::t_div_req i_req,
    output logic              o_done,
    output logic [48:0]       o_quot
);
    import rwfb_pkg::*;
    // computes (2*mag + den) / (2*den)
    logic [49:0] r_num;
    logic [25:0] r_rem;
    logic [24:0] r_dvs;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [25:0] w_sh;

    assign w_sh = {r_rem[24:0], r_num[49]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
                r_rem  <= '0;
                r_num  <= {1'b0, i_req.mag, 1'b0} + {26'd0, i_req.den};
                r_dvs  <= {i_req.den, 1'b0};
            end else if (r_busy) begin
                if (w_sh >= {1'b0, r_dvs}) begin
                    r_rem <= w_sh - {1'b0, r_dvs};
                    r_num <= {r_num[48:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_num <= {r_num[48:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd49) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
    assign o_done = r_done;
    assign o_quot = r_num[48:0];
endmodule

/* rtl/radial_weighted_field_blur.sv */
//------------------------------------------------------------------------------
// radial_weighted_field_blur
// Height field store with a normalized radial-kernel blur query.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
// A query that lies inside the field sweeps the whole (2R+1)^2 window one
// sample per cycle through the single read port of the sample memory, then
// starts the bit-serial divider, or answers invalid if no sample carried
// weight. The next word is taken only after the result has been delivered.
// A query outside the field answers in the next cycle.
// The result sits in an output register. Samples never written read as junk.
module radial_weighted_field_blur #(
    parameter int MAX_ROWS   = 128,
    parameter int MAX_COLS   = 128,
    parameter int MAX_RADIUS = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  rwfb_pkg::t_in_word       i_data,
    output logic                     o_valid,
    input  logic                     i_ready,
    output rwfb_pkg::t_out_word      o_data,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_idx,
    input  logic [rwfb_pkg::CFG_W-1:0] i_cfg_data
);
    import rwfb_pkg::*;
    localparam int AW = $clog2(MAX_ROWS * MAX_COLS);
    localparam int DW = $clog2(MAX_RADIUS + 1) + 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001, S_SCAN = 5'b00010, S_DIV = 5'b00100,
        S_WAIT = 5'b01000, S_OUT = 5'b10000
    } t_state;

    t_state r_state;
    logic [7:0]  r_rows, r_cols;
    logic [3:0]  r_rad;
    logic [10:0] r_rsq;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= 8'd128; r_cols <= 8'd128; r_rad <= 4'd2; r_rsq <= 11'd64;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ROWS:   r_rows <= i_cfg_data[7:0];
                REG_COLS:   r_cols <= i_cfg_data[7:0];
                REG_RADIUS: r_rad  <= i_cfg_data[3:0];
                REG_RSQ:    r_rsq  <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // saturated sizes
    logic [11:0] w_rows, w_cols;
    logic [4:0]  w_rad;
    assign w_rows = ({4'd0, r_rows} > 12'(MAX_ROWS)) ? 12'(MAX_ROWS) : {4'd0, r_rows};
    assign w_cols = ({4'd0, r_cols} > 12'(MAX_COLS)) ? 12'(MAX_COLS) : {4'd0, r_cols};
    assign w_rad  = ({1'b0, r_rad} > 5'(MAX_RADIUS)) ? 5'(MAX_RADIUS) : {1'b0, r_rad};

    logic w_acc, w_inside;
    assign o_ready  = (r_state == S_IDLE);
    assign w_acc    = i_valid && o_ready;
    assign w_inside = ({5'd0, i_data.row} < w_rows) && ({5'd0, i_data.col} < w_cols);

    // sample memory, row-major with a stride of MAX_COLS
    logic signed [15:0] mem [MAX_ROWS*MAX_COLS];
    logic signed [15:0] r_rd;
    logic [AW-1:0] w_waddr, w_raddr;
    logic          w_re;
    assign w_waddr = AW'(int'(i_data.row) * MAX_COLS + int'(i_data.col));
    always_ff @(posedge i_clk) begin
        if (w_acc && i_data.op == OP_WRITE && w_inside)
            mem[w_waddr] <= i_data.height;
        if (w_re)
            r_rd <= mem[w_raddr];
    end

    // scan state
    logic [6:0] r_row, r_col;
    logic signed [DW-1:0] r_di, r_dj;
    logic        r_pv;
    logic [10:0] r_pw;
    logic signed [47:0] r_num;
    logic [23:0] r_den;
    logic signed [12:0] w_ri, w_ci;
    logic [10:0] w_sq;
    logic        w_use;
    assign w_ri = 13'(signed'({6'd0, r_row})) + 13'(r_di);
    assign w_ci = 13'(signed'({6'd0, r_col})) + 13'(r_dj);
    assign w_sq = 11'(r_di * r_di) + 11'(r_dj * r_dj);
    // weight = rsq - 16*d2; d2*16 can exceed 11 bits so compare wide
    logic signed [16:0] w_wt;
    assign w_wt  = signed'({6'd0, r_rsq}) - signed'({2'd0, w_sq, 4'd0});
    assign w_use = (r_state == S_SCAN) && (w_wt > 0) && (w_ri >= 0) && (w_ci >= 0)
                   && (w_ri < signed'({1'b0, w_rows})) && (w_ci < signed'({1'b0, w_cols}));
    assign w_re    = w_use;
    assign w_raddr = AW'(int'(w_ri) * MAX_COLS + int'(w_ci));

    t_div_req w_req;
    logic w_done;
    logic [48:0] w_quot;
    logic signed [27:0] w_prod;
    logic signed [47:0] w_fnum;
    logic [47:0] w_mag;
    assign w_prod = r_rd * signed'({1'b0, r_pw});
    assign w_fnum = r_num + (r_pv ? 48'(w_prod) : 48'sd0);
    assign w_mag  = w_fnum[47] ? 48'(-w_fnum) : w_fnum;
    logic r_neg;

    rwfb_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req),
                    .o_done(w_done), .o_quot(w_quot));

    logic signed [15:0] w_res;
    always_comb begin
        if (w_quot > 49'd32768) w_res = r_neg ? -16'sd32768 : 16'sd32767;
        else if (w_quot == 49'd32768) w_res = r_neg ? -16'sd32768 : 16'sd32767;
        else w_res = r_neg ? -signed'(w_quot[15:0]) : signed'(w_quot[15:0]);
    end

    always_comb begin
        w_req.start = (r_state == S_DIV) && (r_den != 24'd0);
        w_req.mag   = w_mag;
        w_req.den   = r_den;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
            r_pv    <= 1'b0;
        end else begin
            r_pv <= w_use;
            if (w_use) r_pw <= w_wt[10:0];
            unique case (r_state)
                S_IDLE: if (w_acc && i_data.op == OP_QUERY) begin
                    if (!w_inside) begin
                        o_data  <= '{blurred_height: '0, invalid: 1'b1};
                        o_valid <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_row <= i_data.row; r_col <= i_data.col;
                        r_di  <= -DW'(signed'({1'b0, w_rad}));
                        r_dj  <= -DW'(signed'({1'b0, w_rad}));
                        r_num <= '0; r_den <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_pv) r_num <= w_fnum;
                    if (w_use) r_den <= r_den + 24'(w_wt[10:0]);
                    if (r_dj == DW'(signed'({1'b0, w_rad}))) begin
                        r_dj <= -DW'(signed'({1'b0, w_rad}));
                        if (r_di == DW'(signed'({1'b0, w_rad}))) r_state <= S_DIV;
                        r_di <= r_di + DW'(1);
                    end else r_dj <= r_dj + DW'(1);
                end
                S_DIV: begin
                    r_neg <= w_fnum[47];
                    if (r_pv) r_num <= w_fnum;
                    if (r_den == 24'd0) begin
                        o_data  <= '{blurred_height: '0, invalid: 1'b1};
                        o_valid <= 1'b1;
                        r_state <= S_OUT;
                    end else r_state <= S_WAIT;
                end
                S_WAIT: if (w_done) begin
                    o_data  <= '{blurred_height: w_res, invalid: 1'b0};
                    o_valid <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: if (i_ready) begin
                    o_valid <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

/* rtl/rwfb_checker.sv */
//------------------------------------------------------------------------------
// rwfb_checker
// Port-level checks on the blur block, bound to the top level.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "radial_weighted_field_blur_macros.svh"
module rwfb_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_ready,
    input logic                o_valid,
    input logic                i_ready,
    input rwfb_pkg::t_out_word o_data
);
    import rwfb_pkg::*;
    // one word in flight: no input taken while a result waits
    `RWFB_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, o_valid, !o_ready)
    // invalid results carry zero
    `RWFB_ASSERT_IMP(a_inv_zero, i_clk, i_rst_n, o_valid && o_data.invalid, o_data.blurred_height == '0)
    // a stalled result holds
    `RWFB_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_data))
    // delivered result frees the block next cycle
    `RWFB_ASSERT_NXT(a_free, i_clk, i_rst_n, o_valid && i_ready, o_ready)
endmodule

bind radial_weighted_field_blur rwfb_checker u_chk (.*);
